### hdl/packet_timestamp_smoothing_dll_macros.svh
// Assertion macros shared by the timestamp smoothing loop RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef PACKET_TIMESTAMP_SMOOTHING_DLL_MACROS_SVH
`define PACKET_TIMESTAMP_SMOOTHING_DLL_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/ptsd_pkg.sv
// Package for the packet timestamp smoothing loop.
// Holds the payload structs, register indexes and fixed-point constants; no dependencies.
`timescale 1ns / 1ps

package ptsd_pkg;

	localparam int TICK_FRAC_BITS = 16;
	localparam int GAIN_FRAC_BITS = 24;

	// Shared multiplier operand widths.
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 26;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Configuration port.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 26;

	localparam logic [CFG_INDEX_W-1:0] REG_NOMINAL_FRAME_TICKS = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_BYTES         = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_B              = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_C              = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_RESYNC_THRESHOLD    = 3'd4;

	// Ticks in one 128 s wrap of the cycle timer, whole and in Q.16.
	localparam logic [31:0] WRAP_WHOLE = 32'd3145728000;
	localparam logic [50:0] WRAP_Q     = 51'(WRAP_WHOLE) << TICK_FRAC_BITS;
	localparam logic [50:0] HALF_Q     = WRAP_Q >> 1;

	typedef struct packed {
		logic [31:0] cycle_timer;
		logic [11:0] length_bytes;
	} in_item_t;

	typedef struct packed {
		logic        status;
		logic [31:0] timestamp;
		logic [31:0] tail_timestamp;
		logic        tail_valid;
	} out_item_t;

endpackage

### hdl/ptsd_mul.sv
// Shared unsigned multiplier of the smoothing loop, product registered.
// Depends on ptsd_pkg for the operand widths.
`timescale 1ns / 1ps

module ptsd_mul import ptsd_pkg::*; (
	input  logic               clk,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [MUL_P_W-1:0] p
);

	logic [MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign p = p_q;

endmodule

### hdl/packet_timestamp_smoothing_dll.sv
// Top level of the packet timestamp smoothing loop (second-order DLL).
// Depends on ptsd_pkg, ptsd_mul and packet_timestamp_smoothing_dll_macros.svh.
`timescale 1ns / 1ps
`include "packet_timestamp_smoothing_dll_macros.svh"

// Each packet transfer brings the cycle-timer value seen at arrival and the payload length.
// The block converts the arrival to ticks of 24.576 MHz modulo 128 s, compares it with the
// loop's predicted arrival and returns one result transfer per packet. While the loop is
// locked and the error stays within resync_threshold ticks, the result carries the old
// prediction and the loop advances with gains B and C. Otherwise the loop restarts: the
// period becomes nominal_frame_ticks times the whole frames in the packet, the raw arrival
// is returned, and a tail timestamp (arrival minus period) is flagged with tail_valid.
// A zero length returns status 1 with zero fields and leaves the loop untouched.
// The block takes one packet at a time and holds in_stall high while it works.
// A zero-length packet goes straight to the last step, and a restart runs the
// one-bit-per-cycle divider that counts frames. All products go through one registered
// 32 x 26 multiplier, used once on a restart and twice (gain B, then gain C) on a locked
// update. The finished result sits in an output register, so the next packet is taken
// while it waits; the block only waits at its last step if the previous result has not
// yet been transferred. Configuration is written through cfg_wen, cfg_index and cfg_data;
// the user must write it only while the block is idle; the block does not enforce this.

module packet_timestamp_smoothing_dll import ptsd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data,
	input  logic                   cfg_wen,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// Sequencer states.
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_TICKS = 4'd1;
	localparam logic [3:0] S_ERR   = 4'd2;
	localparam logic [3:0] S_CMP   = 4'd3;
	localparam logic [3:0] S_DIV   = 4'd4;
	localparam logic [3:0] S_MULP  = 4'd5;
	localparam logic [3:0] S_RI1   = 4'd6;
	localparam logic [3:0] S_RI2   = 4'd7;
	localparam logic [3:0] S_MULB  = 4'd8;
	localparam logic [3:0] S_MULC  = 4'd9;
	localparam logic [3:0] S_UPD   = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	localparam logic [3:0] DIV_LAST = 4'd11;

	// Configuration registers.
	logic [25:0] nom_ticks_q;
	logic [10:0] frame_bytes_q;
	logic [23:0] gain_b_q;
	logic [23:0] gain_c_q;
	logic [15:0] thresh_q;

	// Loop state.
	logic               locked_q;
	logic signed [49:0] pred_q;
	logic signed [39:0] period_q;

	// Working registers.
	logic [3:0]         state_q;
	logic [31:0]        ct_q;
	logic [31:0]        ticks_q;
	logic signed [50:0] err_q;
	logic [31:0]        emag_q;
	logic               eneg_q;
	logic [10:0]        rem_q;
	logic [11:0]        quo_q;
	logic [3:0]         div_cnt_q;
	logic signed [32:0] gb_q;
	out_item_t          res_q;
	out_item_t          out_data_q;
	logic               out_valid_q;

	// Shared multiplier.
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;

	ptsd_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	always_comb begin
		case (state_q)
			S_MULP: begin
				// A zero frame size counts as zero frames.
				mul_a = (frame_bytes_q == 11'd0) ? '0 : MUL_A_W'(quo_q);
				mul_b = nom_ticks_q;
			end
			S_MULC: begin
				mul_a = emag_q;
				mul_b = MUL_B_W'(gain_c_q);
			end
			default: begin
				mul_a = emag_q;
				mul_b = MUL_B_W'(gain_b_q);
			end
		endcase
	end

	// Arrival in ticks: (secs * 8000 + cycles) * 3072 + offset, then one wrap.
	logic [19:0] sec_cyc;
	logic [32:0] tick_sum;
	logic [31:0] ticks_w;

	always_comb begin
		sec_cyc  = 20'(ct_q[31:25]) * 20'd8000 + 20'(ct_q[24:12]);
		tick_sum = 33'({sec_cyc, 11'b0}) + 33'({sec_cyc, 10'b0}) + 33'(ct_q[11:0]);
		if (tick_sum >= 33'(WRAP_WHOLE)) begin
			ticks_w = 32'(tick_sum - 33'(WRAP_WHOLE));
		end else begin
			ticks_w = tick_sum[31:0];
		end
	end

	// Arrival in Q.16 ticks, and the phase error wrapped at minus 64 s.
	logic signed [50:0] tq_s;
	logic signed [50:0] err_raw;
	logic signed [50:0] err_w;

	always_comb begin
		tq_s    = $signed(51'(ticks_q) << TICK_FRAC_BITS);
		err_raw = tq_s - 51'(pred_q);
		if (err_raw < -$signed(HALF_Q)) begin
			err_w = err_raw + $signed(WRAP_Q);
		end else begin
			err_w = err_raw;
		end
	end

	// Error magnitude and the restart decision.
	logic [50:0] emag_w;
	logic [50:0] thresh_w;
	logic        restart_w;

	always_comb begin
		emag_w    = err_q[50] ? $unsigned(-err_q) : $unsigned(err_q);
		thresh_w  = 51'(thresh_q) << TICK_FRAC_BITS;
		restart_w = !locked_q || (emag_w > thresh_w);
	end

	// One restoring division step: frames = length / frame_bytes.
	logic [11:0] div_trial;
	logic        div_bit;

	always_comb begin
		div_trial = {rem_q, quo_q[11]};
		div_bit   = (div_trial >= 12'(frame_bytes_q));
	end

	// Gain product scaled back by the gain fraction, truncated toward zero.
	logic [31:0] gmag;
	logic signed [32:0] gterm;

	always_comb begin
		gmag  = mul_p[GAIN_FRAC_BITS +: 32];
		gterm = eneg_q ? -$signed({1'b0, gmag}) : $signed({1'b0, gmag});
	end

	// Locked update: prediction advances by B*e plus the old period, period by C*e.
	logic signed [50:0] upd_sum;
	logic signed [50:0] upd_pred;
	logic signed [40:0] per_sum;
	logic signed [39:0] per_sat;

	always_comb begin
		upd_sum = 51'(pred_q) + 51'(gb_q) + 51'(period_q);
		if (upd_sum[50]) begin
			upd_pred = upd_sum + $signed(WRAP_Q);
		end else if ($unsigned(upd_sum) >= WRAP_Q) begin
			upd_pred = upd_sum - $signed(WRAP_Q);
		end else begin
			upd_pred = upd_sum;
		end
		per_sum = 41'(period_q) + 41'(gterm);
		if (per_sum[40] != per_sum[39]) begin
			per_sat = per_sum[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
		end else begin
			per_sat = per_sum[39:0];
		end
	end

	// Restart: new prediction is arrival plus period; tail is arrival minus period,
	// truncated toward zero to whole ticks and moved into the 128 s range when negative.
	logic signed [50:0] ri_sum;
	logic signed [50:0] ri_pred;
	logic signed [50:0] tail_d;
	logic [50:0]        tail_neg;
	logic [31:0]        tail_mag;
	logic [31:0]        tail_w;

	always_comb begin
		ri_sum = tq_s + 51'(period_q);
		if ($unsigned(ri_sum) >= WRAP_Q) begin
			ri_pred = ri_sum - $signed(WRAP_Q);
		end else begin
			ri_pred = ri_sum;
		end
		tail_d   = tq_s - 51'(period_q);
		tail_neg = $unsigned(-tail_d);
		tail_mag = 32'(tail_neg[50:TICK_FRAC_BITS]);
		if (!tail_d[50]) begin
			tail_w = tail_d[47:16];
		end else if (tail_mag == 32'd0) begin
			tail_w = 32'd0;
		end else begin
			tail_w = WRAP_WHOLE - tail_mag;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nom_ticks_q   <= 26'd33554432;
			frame_bytes_q <= 11'd72;
			gain_b_q      <= 24'd298156;
			gain_c_q      <= 24'd2649;
			thresh_q      <= 16'd10000;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_NOMINAL_FRAME_TICKS: nom_ticks_q   <= cfg_data;
				REG_FRAME_BYTES:         frame_bytes_q <= cfg_data[10:0];
				REG_GAIN_B:              gain_b_q      <= cfg_data[23:0];
				REG_GAIN_C:              gain_c_q      <= cfg_data[23:0];
				REG_RESYNC_THRESHOLD:    thresh_q      <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and loop state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			locked_q    <= 1'b0;
			pred_q      <= '0;
			period_q    <= '0;
			out_valid_q <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			// In the last step the output register is refilled by that step itself.
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ct_q  <= in_data.cycle_timer;
						quo_q <= in_data.length_bytes;
						if (in_data.length_bytes == 12'd0) begin
							res_q   <= '{status: 1'b1, timestamp: 32'd0,
								tail_timestamp: 32'd0, tail_valid: 1'b0};
							state_q <= S_DONE;
						end else begin
							state_q <= S_TICKS;
						end
					end
				end
				S_TICKS: begin
					ticks_q <= ticks_w;
					state_q <= S_ERR;
				end
				S_ERR: begin
					err_q   <= err_w;
					state_q <= S_CMP;
				end
				S_CMP: begin
					emag_q <= emag_w[31:0];
					eneg_q <= err_q[50];
					if (restart_w) begin
						rem_q     <= '0;
						div_cnt_q <= '0;
						state_q   <= S_DIV;
					end else begin
						state_q <= S_MULB;
					end
				end
				S_DIV: begin
					rem_q     <= div_bit ? 11'(div_trial - 12'(frame_bytes_q)) : div_trial[10:0];
					quo_q     <= {quo_q[10:0], div_bit};
					div_cnt_q <= div_cnt_q + 4'd1;
					if (div_cnt_q == DIV_LAST) begin
						state_q <= S_MULP;
					end
				end
				S_MULP: begin
					state_q <= S_RI1;
				end
				S_RI1: begin
					// Nominal period times frames stays below 2^38, so no saturation.
					period_q <= $signed(40'(mul_p[37:0]));
					state_q  <= S_RI2;
				end
				S_RI2: begin
					pred_q   <= 50'(ri_pred);
					locked_q <= 1'b1;
					res_q    <= '{status: 1'b0, timestamp: ticks_q,
						tail_timestamp: tail_w, tail_valid: 1'b1};
					state_q  <= S_DONE;
				end
				S_MULB: begin
					state_q <= S_MULC;
				end
				S_MULC: begin
					gb_q    <= gterm;
					state_q <= S_UPD;
				end
				S_UPD: begin
					res_q    <= '{status: 1'b0, timestamp: pred_q[47:16],
						tail_timestamp: 32'd0, tail_valid: 1'b0};
					pred_q   <= 50'(upd_pred);
					period_q <= per_sat;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_data_q  <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A restart result is always a valid packet.
	`PTSD_ASSERT_NOW(a_tail_ok, out_valid && out_data.tail_valid, !out_data.status, "tail flagged on invalid packet")
	// Once locked, the loop only restarts, it never drops the lock.
	`PTSD_ASSERT_NEXT(a_lock_kept, locked_q, locked_q, "loop lock dropped")
	// An accepted packet always starts work.
	`PTSD_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall, "accepted packet left block idle")
	// The frame divider never runs past its last step.
	`PTSD_ASSERT_NOW(a_div_bound, state_q == S_DIV, div_cnt_q <= DIV_LAST, "divider step count overrun")

endmodule

### verif/tb_top.sv
// Self-checking testbench for packet_timestamp_smoothing_dll.
// Depends on ptsd_pkg and the RTL top level. A built-in model of the loop predicts every
// result transfer, and the run moves through several register settings and random stalls.
`timescale 1ns / 1ps

module tb_top;
	import ptsd_pkg::*;

	// Tick arithmetic of the cycle timer and the loop, all held in signed 64-bit values.
	localparam longint TICKS_PER_SEC = 24576000;
	localparam longint TICKS_PER_CYC = 3072;
	localparam longint WRAP_T        = longint'({32'd0, WRAP_WHOLE});
	localparam longint WRAP_TQ       = WRAP_T <<< TICK_FRAC_BITS;
	localparam longint HALF_TQ       = WRAP_TQ >>> 1;
	localparam longint PERIOD_MAX    = (longint'(1) <<< 39) - 1;
	localparam longint PERIOD_MIN    = -(longint'(1) <<< 39);

	// Outlasts a restart, so this covers any work still in flight.
	localparam int SETTLE_CYCLES = 24;
	localparam int END_GUARD     = 50;
	// The long hold-off on the result side, in cycles.
	localparam int LONG_HOLD     = 200;
	// Cycles without any transfer or register write before the run is declared hung.
	// The longest correct quiet stretch is the long hold-off plus one random stall.
	localparam int HANG_LIMIT    = 2000;
	localparam int REPORT_LIMIT  = 10;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      cfg_wen;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Register values as the loop sees them, mirrored on every write.
	logic [25:0] cfg_nominal;
	logic [10:0] cfg_frame_bytes;
	logic [23:0] cfg_gain_b;
	logic [23:0] cfg_gain_c;
	logic [15:0] cfg_resync;

	// Loop state of the model: lock flag, predicted arrival and period, both in Q.16 ticks.
	logic   loop_locked;
	longint pred_time_q;
	longint period_q;

	// Expected result transfers, oldest first.
	out_item_t pending_stamps[$];
	int        stamp_errors;
	int        quiet_cycles;

	// Random stalls on both sides are switched off for the last part of the run.
	logic idle_en;
	// Set by the stimulus to ask the result side for one long hold-off.
	logic long_hold_req;

	packet_timestamp_smoothing_dll i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ------------------------------------------------------------------------------------
	// Model of the loop
	// ------------------------------------------------------------------------------------

	function automatic void model_reset();
		cfg_nominal     = 26'd33554432;
		cfg_frame_bytes = 11'd72;
		cfg_gain_b      = 24'd298156;
		cfg_gain_c      = 24'd2649;
		cfg_resync      = 16'd10000;
		loop_locked     = 1'b0;
		pred_time_q     = 0;
		period_q        = 0;
	endfunction

	// Gain product: the magnitude of the error times the Q0.24 gain, truncated, so the
	// result rounds toward zero and then takes the sign of the error.
	function automatic longint loop_gain(longint err, logic [23:0] gain);
		longint unsigned mag;
		longint unsigned prod;
		mag  = (err < 0) ? -err : err;
		prod = (mag * {40'd0, gain}) >> GAIN_FRAC_BITS;
		return (err < 0) ? -longint'(prod) : longint'(prod);
	endfunction

	// The period register is 40 bits wide and saturates rather than wrapping.
	function automatic longint clamp_period(longint v);
		if (v > PERIOD_MAX)
			return PERIOD_MAX;
		if (v < PERIOD_MIN)
			return PERIOD_MIN;
		return v;
	endfunction

	// The predicted arrival is kept in [0, 128 s); one correction is always enough.
	function automatic longint wrap_pred(longint v);
		if (v >= WRAP_TQ)
			v -= WRAP_TQ;
		if (v < 0)
			v += WRAP_TQ;
		return v;
	endfunction

	// Works out the result of one accepted packet and advances the model's loop state.
	function automatic out_item_t smooth_stamp(in_item_t pkt);
		out_item_t res;
		longint secs, cycs, ofs;
		longint ticks, ticks_q, err, emag, thr_q;
		longint nom, frames, diff, tail;
		res = '0;
		// A zero length is rejected and the loop is left exactly as it was.
		if (pkt.length_bytes == 12'd0) begin
			res.status = 1'b1;
			return res;
		end
		// Cycle and offset fields beyond their nominal ranges are used as they are.
		secs  = longint'({57'd0, pkt.cycle_timer[31:25]});
		cycs  = longint'({51'd0, pkt.cycle_timer[24:12]});
		ofs   = longint'({52'd0, pkt.cycle_timer[11:0]});
		ticks = secs * TICKS_PER_SEC + cycs * TICKS_PER_CYC + ofs;
		if (ticks >= WRAP_T)
			ticks -= WRAP_T;
		ticks_q = ticks <<< TICK_FRAC_BITS;
		// An error below -64 s is really a small positive one across the wrap.
		err = ticks_q - pred_time_q;
		if (err < -HALF_TQ)
			err += WRAP_TQ;
		emag  = (err < 0) ? -err : err;
		thr_q = longint'({48'd0, cfg_resync});
		thr_q = thr_q <<< TICK_FRAC_BITS;
		if (!loop_locked || emag > thr_q) begin
			// Restart: the period is the nominal frame time times the whole frames.
			nom = longint'({38'd0, cfg_nominal});
			if (cfg_frame_bytes != 11'd0)
				frames = longint'({52'd0, pkt.length_bytes / 12'(cfg_frame_bytes)});
			else
				frames = 0;
			period_q    = clamp_period(nom * frames);
			pred_time_q = wrap_pred(ticks_q + period_q);
			// The tail is truncated toward zero, then moved into range if negative.
			diff = ticks_q - period_q;
			if (diff < 0)
				tail = -((-diff) >>> TICK_FRAC_BITS);
			else
				tail = diff >>> TICK_FRAC_BITS;
			if (tail < 0)
				tail += WRAP_T;
			loop_locked        = 1'b1;
			res.timestamp      = 32'(ticks);
			res.tail_timestamp = 32'(tail);
			res.tail_valid     = 1'b1;
		end else begin
			// Locked: the old prediction goes out, then the loop moves by B and C.
			res.timestamp = 32'(pred_time_q >>> TICK_FRAC_BITS);
			pred_time_q   = wrap_pred(pred_time_q + loop_gain(err, cfg_gain_b) + period_q);
			period_q      = clamp_period(period_q + loop_gain(err, cfg_gain_c));
		end
		return res;
	endfunction

	// ------------------------------------------------------------------------------------
	// Monitors and watchdog
	// ------------------------------------------------------------------------------------

	// Every accepted packet transfer is predicted at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			pending_stamps.push_back(smooth_stamp(in_data));
	end

	// Every accepted result transfer is compared with the oldest prediction.
	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_stamps.size() == 0) begin
				stamp_errors++;
				if (stamp_errors <= REPORT_LIMIT)
					$display("%0t: result transfer with none expected: %s%0b %s%0d %s%0d %s%0b",
						$realtime, "status=", out_data.status,
						"ts=", out_data.timestamp,
						"tail=", out_data.tail_timestamp,
						"tv=", out_data.tail_valid);
			end else begin
				want = pending_stamps.pop_front();
				if (out_data.status !== want.status || out_data.timestamp !== want.timestamp ||
				    out_data.tail_timestamp !== want.tail_timestamp ||
				    out_data.tail_valid !== want.tail_valid) begin
					stamp_errors++;
					if (stamp_errors <= REPORT_LIMIT)
						$display({"%0t: mismatch: expected status=%0b ts=%0d tail=%0d tv=%0b,",
							" got status=%0b ts=%0d tail=%0d tv=%0b"},
							$realtime, want.status, want.timestamp, want.tail_timestamp,
							want.tail_valid, out_data.status, out_data.timestamp,
							out_data.tail_timestamp, out_data.tail_valid);
				end
			end
		end
	end

	// Counts cycles in which nothing moves at all; a hung block ends the run here.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == HANG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// The result side stalls in random bursts, and once on request for a long stretch so
	// that the block backs up and stalls its own input while packets keep being offered.
	initial begin : result_stall_driver
		int burst;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall <= 1'b0;
				long_hold_req = 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 13);
				out_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------------------

	// Called at a falling edge. Offers one packet, sometimes with a random gap in front of it,
	// and returns at the falling edge after its transfer. Valid stays high for the next call.
	task automatic send_packet(input in_item_t pkt);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_data  <= pkt;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		@(negedge clk);
	endtask

	function automatic in_item_t raw_packet(logic [31:0] stamp, logic [11:0] len);
		in_item_t pkt;
		pkt.cycle_timer  = stamp;
		pkt.length_bytes = len;
		return pkt;
	endfunction

	// Encodes whole ticks below 128 s as a well-formed cycle-timer value.
	function automatic in_item_t pack_arrival(longint whole, logic [11:0] len);
		longint rem;
		rem = whole % TICKS_PER_SEC;
		return raw_packet({7'(whole / TICKS_PER_SEC), 13'(rem / TICKS_PER_CYC),
			12'(rem % TICKS_PER_CYC)}, len);
	endfunction

	// The model's current prediction, offset by some ticks and wrapped into 128 s.
	function automatic longint near_prediction(longint offset);
		longint t;
		t = (pred_time_q >>> TICK_FRAC_BITS) + offset;
		if (t < 0)
			t += WRAP_T;
		else if (t >= WRAP_T)
			t -= WRAP_T;
		return t;
	endfunction

	// Lowers valid and waits until every expected result has arrived and the block is idle.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_stamps.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Drives one register write; the caller lowers the write enable after the last one.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		case (idx)
			REG_NOMINAL_FRAME_TICKS: cfg_nominal     = val;
			REG_FRAME_BYTES:         cfg_frame_bytes = val[10:0];
			REG_GAIN_B:              cfg_gain_b      = val[23:0];
			REG_GAIN_C:              cfg_gain_c      = val[23:0];
			REG_RESYNC_THRESHOLD:    cfg_resync      = val[15:0];
			default: ;
		endcase
	endtask

	// Writes all five registers once the block has gone idle.
	task automatic apply_setting(input logic [CFG_DATA_W-1:0] nom,
	                             input logic [CFG_DATA_W-1:0] fb,
	                             input logic [CFG_DATA_W-1:0] gb,
	                             input logic [CFG_DATA_W-1:0] gc,
	                             input logic [CFG_DATA_W-1:0] thr);
		settle_block();
		write_reg(REG_NOMINAL_FRAME_TICKS, nom);
		write_reg(REG_FRAME_BYTES, fb);
		write_reg(REG_GAIN_B, gb);
		write_reg(REG_GAIN_C, gc);
		write_reg(REG_RESYNC_THRESHOLD, thr);
		cfg_wen <= 1'b0;
	endtask

	// Mixed packet stream. Most packets arrive close to the predicted time, so the loop
	// stays locked for long runs; the rest are rejected packets, random cycle-timer values
	// and jumps that force a restart.
	task automatic send_traffic(input int count);
		int       pick;
		int       span;
		int       jit;
		in_item_t pkt;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			span = (cfg_resync > 16'd1) ? $urandom_range(0, cfg_resync - 1) : 0;
			if (pick < 60)
				span = span / 16;
			jit = int'($urandom_range(0, 2 * span)) - span;
			if (pick < 5) begin
				pkt = raw_packet($urandom, 12'd0);
			end else if (pick < 15) begin
				pkt = raw_packet($urandom, 12'($urandom_range(0, 4095)));
			end else if (pick < 20) begin
				pkt = pack_arrival(longint'({32'd0, $urandom_range(0, WRAP_WHOLE - 1)}),
					12'($urandom_range(1, 4095)));
			end else begin
				pkt = pack_arrival(near_prediction(longint'(jit)), 12'($urandom_range(1, 4095)));
			end
			send_packet(pkt);
		end
	endtask

	// ------------------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------------------

	// Directed packets under the reset register values: 576 bytes is eight 72-byte frames
	// of 512 ticks, so a restart sets a period of 4096 ticks.
	task automatic test_directed_defaults();
		// Rejected packet while unlocked, then the first restart from time zero, whose
		// tail falls below zero and wraps to the top of the 128 s range.
		send_packet(raw_packet(32'd0, 12'd0));
		send_packet(raw_packet(32'd0, 12'd576));
		// Small positive error: locked update.
		send_packet(pack_arrival(near_prediction(4), 12'd4095));
		// Rejected packet while locked, with every cycle-timer bit set.
		send_packet(raw_packet(32'hFFFF_FFFF, 12'd0));
		send_packet(pack_arrival(near_prediction(0), 12'd576));
		send_packet(pack_arrival(near_prediction(-9000), 12'd576));
		send_packet(pack_arrival(near_prediction(10000), 12'd576));
		// Just above the threshold forces a restart.
		send_packet(pack_arrival(near_prediction(10001), 12'd576));
		// Cycle timer past 128 s, shorter than one frame: zero frames, zero period.
		send_packet(raw_packet(32'hFFFF_FFFF, 12'd1));
		// Cycle and offset fields above their nominal ranges, largest length.
		send_packet(raw_packet({7'd0, 13'd8000, 12'd3072}, 12'd4095));
		// Restart just below 128 s: the prediction lands just below the top of the range.
		send_packet(pack_arrival(WRAP_T - 10000, 12'd576));
		// Arrival near zero against a prediction near the top: the error wraps at -64 s.
		send_packet(pack_arrival(50, 12'd576));
		send_packet(pack_arrival(near_prediction(1), 12'd576));
		// Arrival smaller than the period, within the threshold of the wrapped prediction: locked update.
		send_packet(pack_arrival(100, 12'd576));
		send_packet(pack_arrival(near_prediction(-3), 12'd72));
	endtask

	// Register extremes, each followed by a short stream.
	task automatic test_register_extremes();
		// Frame time of one fraction step, frame size of 4 bytes, zero gains, zero threshold: nearly every
		// packet restarts the loop.
		apply_setting(26'd1, 26'd4, 26'd0, 26'd0, 26'd0);
		send_traffic(40);
		// Largest values everywhere but the frame size, which is 1024 bytes.
		apply_setting(26'd67108863, 26'd1024, 26'd16777215, 26'd16777215, 26'd65535);
		send_packet(pack_arrival(WRAP_T - 1, 12'd4095));
		send_traffic(40);
		// Frame time of 512 ticks plus one fraction step, frames of 4 bytes. An arrival
		// of 512 ticks then leaves a tail just below zero, which truncates to zero.
		apply_setting(26'd33554433, 26'd4, 26'd298156, 26'd2649, 26'd0);
		send_packet(pack_arrival(512, 12'd4));
		send_packet(pack_arrival(100000, 12'd8));
		send_traffic(40);
		// Back to the reset values.
		apply_setting(26'd33554432, 26'd72, 26'd298156, 26'd2649, 26'd10000);
		send_traffic(40);
	endtask

	// The result side holds off for a long stretch while packets keep coming.
	task automatic test_result_holdoff();
		long_hold_req = 1'b1;
		send_traffic(30);
	endtask

	// The packet side pauses until every expected result has come, then resumes.
	task automatic test_sender_pause();
		send_traffic(10);
		in_valid <= 1'b0;
		while (pending_stamps.size() != 0)
			@(negedge clk);
		send_traffic(10);
	endtask

	// Random register settings, each with a long stream.
	task automatic test_random_settings(input int rounds, input int per_round);
		logic [CFG_DATA_W-1:0] nom, fb, gb, gc, thr;
		for (int r = 0; r < rounds; r++) begin
			nom = ($urandom_range(0, 1) == 0) ? CFG_DATA_W'($urandom_range(1, 67108863))
			                                  : CFG_DATA_W'($urandom_range(16000000, 40000000));
			fb  = CFG_DATA_W'($urandom_range(4, 1024));
			gb  = ($urandom_range(0, 1) == 0) ? CFG_DATA_W'($urandom_range(0, 16777215))
			                                  : CFG_DATA_W'($urandom_range(0, 1 << 20));
			gc  = ($urandom_range(0, 1) == 0) ? CFG_DATA_W'($urandom_range(0, 16777215))
			                                  : CFG_DATA_W'($urandom_range(0, 1 << 14));
			thr = CFG_DATA_W'($urandom_range(0, 65535));
			apply_setting(nom, fb, gb, gc, thr);
			send_traffic(per_round);
		end
	endtask

	// Last part: no random stalls on either side, so each packet is taken as soon as the block is idle.
	task automatic test_full_rate();
		apply_setting(26'd33554432, 26'd72, 26'd298156, 26'd2649, 26'd10000);
		idle_en = 1'b0;
		send_traffic(200);
	endtask

	initial begin : test_sequence
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_wen       = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		idle_en       = 1'b1;
		long_hold_req = 1'b0;
		stamp_errors  = 0;
		quiet_cycles  = 0;
		model_reset();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_defaults();
		test_register_extremes();
		test_result_holdoff();
		test_sender_pause();
		test_random_settings(8, 150);
		test_full_rate();

		// Drain, give the block time to show any stray result, then judge.
		settle_block();
		repeat (END_GUARD) @(negedge clk);
		if (stamp_errors == 0 && pending_stamps.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
